FILE: sv/skp_pkg.sv
// skyline packer package: payload structs, register indexes and defaults
// no dependencies
package skp_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int COORD_BITS_DEF   = 12;
  localparam int REG_BITS         = 13;
  localparam int POS_BITS         = 12;
  localparam int CFG_IDX_BITS     = 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_ATLAS_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ATLAS_HEIGHT = 1'b1;

  localparam logic [REG_BITS-1:0] ATLAS_SIZE_RST = 13'd512;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_CLEAR   = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [REG_BITS-1:0] req_width;
    logic [REG_BITS-1:0] req_height;
  } in_item_t;

  typedef struct packed {
    logic                found;
    logic [POS_BITS-1:0] pos_x;
    logic [POS_BITS-1:0] pos_y;
  } out_item_t;

endpackage

FILE: sv/skyline_rect_packer.sv
// skyline rectangle packer top level: sequencer over the segment ram
// depends on skp_pkg and skp_ram
// sequence: a clear rewrites the initial segment before its result, and a refused request is
//   answered straight from idle; a placed request reads each segment under the span for every
//   start in the fit scan (up to n*n reads), then moves entries for insert, trim and merge drops,
//   and makes a merge pass over the segments; one ram access at a time sets the pace
// throughput: one item at a time, busy stays high until the result strobe
// reset: synchronous; the first cycle after reset writes the single initial segment, busy high
module skyline_rect_packer #(
  parameter int MAX_SEGMENTS = skp_pkg::MAX_SEGMENTS_DEF,
  parameter int COORD_BITS   = skp_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  skp_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  output skp_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [skp_pkg::CFG_IDX_BITS-1:0]    cfg_addr,
  input  logic [skp_pkg::REG_BITS-1:0]        cfg_wdata
);
  import skp_pkg::*;

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int CB = COORD_BITS;
  localparam int AW = ((CB > REG_BITS) ? CB : REG_BITS) + 3;
  localparam int EW = 3 * CB;

  localparam logic [4:0] ST_INIT   = 5'd0;
  localparam logic [4:0] ST_IDLE   = 5'd1;
  localparam logic [4:0] ST_S_RD   = 5'd2;
  localparam logic [4:0] ST_S_PROC = 5'd3;
  localparam logic [4:0] ST_I_RD   = 5'd4;
  localparam logic [4:0] ST_I_WR   = 5'd5;
  localparam logic [4:0] ST_T_RD   = 5'd6;
  localparam logic [4:0] ST_T_PROC = 5'd7;
  localparam logic [4:0] ST_D_RD   = 5'd8;
  localparam logic [4:0] ST_D_WR   = 5'd9;
  localparam logic [4:0] ST_M_RD0  = 5'd10;
  localparam logic [4:0] ST_M_PR0  = 5'd11;
  localparam logic [4:0] ST_M_RD1  = 5'd12;
  localparam logic [4:0] ST_M_PR1  = 5'd13;
  localparam logic [4:0] ST_CLEAR  = 5'd14;

  function automatic logic signed [AW-1:0] zc(input logic [CB-1:0] v);
    zc = $signed({{(AW-CB){1'b0}}, v});
  endfunction

  function automatic logic signed [AW-1:0] zr(input logic [REG_BITS-1:0] v);
    zr = $signed({{(AW-REG_BITS){1'b0}}, v});
  endfunction

  function automatic logic signed [AW-1:0] eff(input logic [REG_BITS-1:0] v);
    logic signed [AW-1:0] top;
    top = $signed(AW'(1) <<< CB);
    if (zr(v) < $signed(AW'(3))) eff = $signed(AW'(3));
    else if (zr(v) > top)        eff = top;
    else                         eff = zr(v);
  endfunction

  logic [4:0]            state_r, state_nxt;
  logic [REG_BITS-1:0]   aw_r, aw_nxt, ah_r, ah_nxt;
  logic [REG_BITS-1:0]   w_r, w_nxt, h_r, h_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt, s_r, s_nxt, k_r, k_nxt, j_r, j_nxt, best_r, best_nxt;
  logic                  first_r, first_nxt, have_r, have_nxt, ret_merge_r, ret_merge_nxt;
  logic signed [AW-1:0]  y_r, y_nxt, left_r, left_nxt, edge_r, edge_nxt;
  logic signed [AW-1:0]  btop_r, btop_nxt;
  logic [CB-1:0]         sw_r, sw_nxt, bw_r, bw_nxt, px_r, px_nxt, py_r, py_nxt;
  logic [CB-1:0]         cx_r, cx_nxt, cy_r, cy_nxt, cw_r, cw_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_r, out_nxt;

  logic                  ram_we;
  logic [IW-1:0]         ram_waddr, ram_raddr;
  logic [EW-1:0]         ram_wdata, ram_rdata;
  logic [CB-1:0]         rd_x, rd_y, rd_w;

  logic signed [AW-1:0]  wa, ha, ny, ntop, nleft, nw, cut_w;
  logic [CB-1:0]         swk;
  logic                  better;

  assign rd_x = ram_rdata[EW-1 -: CB];
  assign rd_y = ram_rdata[2*CB-1 -: CB];
  assign rd_w = ram_rdata[CB-1:0];

  assign wa = eff(aw_r);
  assign ha = eff(ah_r);

  skp_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // fit walk and trim step arithmetic on the entry just read
  always_comb begin
    ny    = (first_r || zc(rd_y) > y_r) ? zc(rd_y) : y_r;
    ntop  = ny + zr(h_r);
    nleft = (first_r ? zr(w_r) : left_r) - zc(rd_w);
    swk   = first_r ? rd_w : sw_r;
    better = !have_r || (ntop < btop_r) || (ntop == btop_r && swk < bw_r);
    cut_w = edge_r - zc(rd_x);
    nw    = zc(rd_w) - cut_w;
  end

  always_comb begin
    state_nxt     = state_r;
    aw_nxt        = aw_r;
    ah_nxt        = ah_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    cnt_nxt       = cnt_r;
    s_nxt         = s_r;
    k_nxt         = k_r;
    j_nxt         = j_r;
    best_nxt      = best_r;
    first_nxt     = first_r;
    have_nxt      = have_r;
    ret_merge_nxt = ret_merge_r;
    y_nxt         = y_r;
    left_nxt      = left_r;
    edge_nxt      = edge_r;
    btop_nxt      = btop_r;
    sw_nxt        = sw_r;
    bw_nxt        = bw_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cw_nxt        = cw_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = k_r[IW-1:0];
    ram_wdata     = {CB'(1), CB'(1), CB'(wa - $signed(AW'(2)))};
    ram_raddr     = k_r[IW-1:0];

    if (cfg_we) begin
      unique case (cfg_addr)
        REG_ATLAS_WIDTH:  aw_nxt = cfg_wdata;
        REG_ATLAS_HEIGHT: ah_nxt = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      ST_INIT, ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        cnt_nxt   = CW'(1);
        state_nxt = ST_IDLE;
        if (state_r == ST_CLEAR) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
        end
      end
      ST_IDLE: begin
        if (start) begin
          w_nxt = in_data.req_width;
          h_nxt = in_data.req_height;
          if (in_data.kind == KIND_CLEAR) begin
            state_nxt = ST_CLEAR;
          end else if (in_data.req_width == '0 || in_data.req_height == '0 ||
                       cnt_r == CW'(MAX_SEGMENTS)) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
          end else begin
            s_nxt     = '0;
            k_nxt     = '0;
            first_nxt = 1'b1;
            have_nxt  = 1'b0;
            state_nxt = ST_S_RD;
          end
        end
      end
      ST_S_RD: begin
        if (k_r >= cnt_r) begin
          // span runs past the last segment: this start does not fit
          first_nxt = 1'b1;
          s_nxt     = s_r + CW'(1);
          k_nxt     = s_r + CW'(1);
          if ({1'b0, s_r} + (CW+1)'(1) >= {1'b0, cnt_r}) state_nxt = ST_I_RD;
          else state_nxt = ST_S_RD;
          if (!have_r && {1'b0, s_r} + (CW+1)'(1) >= {1'b0, cnt_r}) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            state_nxt     = ST_IDLE;
          end
          k_nxt = ({1'b0, s_r} + (CW+1)'(1) >= {1'b0, cnt_r}) ? cnt_r : s_r + CW'(1);
        end else begin
          ram_raddr = k_r[IW-1:0];
          state_nxt = ST_S_PROC;
        end
      end
      ST_S_PROC: begin
        logic done_start;
        done_start = 1'b0;
        if (first_r) sw_nxt = rd_w;
        first_nxt = 1'b0;
        if (first_r && (zc(rd_x) + zr(w_r) > wa - $signed(AW'(1)))) begin
          done_start = 1'b1;
        end else if (ntop > ha - $signed(AW'(1))) begin
          done_start = 1'b1;
        end else if (nleft <= $signed(AW'(0))) begin
          done_start = 1'b1;
          if (better) begin
            have_nxt = 1'b1;
            btop_nxt = ntop;
            bw_nxt   = swk;
            best_nxt = s_r;
            px_nxt   = first_r ? rd_x : px_r;
            py_nxt   = CB'(ny);
          end
        end else begin
          y_nxt    = ny;
          left_nxt = nleft;
          k_nxt    = k_r + CW'(1);
          if (first_r) px_nxt = px_r;
          state_nxt = ST_S_RD;
        end
        if (first_r) begin
          cx_nxt = rd_x;
        end
        if (done_start) begin
          if (first_r && nleft <= $signed(AW'(0)) && better &&
              !(zc(rd_x) + zr(w_r) > wa - $signed(AW'(1))) &&
              !(ntop > ha - $signed(AW'(1)))) begin
            px_nxt = rd_x;
          end else if (!first_r && nleft <= $signed(AW'(0)) && better &&
                       !(ntop > ha - $signed(AW'(1)))) begin
            px_nxt = cx_r;
          end
          first_nxt = 1'b1;
          left_nxt  = zr(w_r);
          s_nxt     = s_r + CW'(1);
          if ({1'b0, s_r} + (CW+1)'(1) >= {1'b0, cnt_r}) begin
            k_nxt = cnt_r;
            if (!(have_r || (nleft <= $signed(AW'(0)) && !(ntop > ha - $signed(AW'(1))) &&
                  !(first_r && (zc(rd_x) + zr(w_r) > wa - $signed(AW'(1))))))) begin
              out_valid_nxt = 1'b1;
              out_nxt       = '0;
              state_nxt     = ST_IDLE;
            end else begin
              state_nxt = ST_I_RD;
            end
          end else begin
            k_nxt     = s_r + CW'(1);
            state_nxt = ST_S_RD;
          end
        end else if (first_r) begin
          left_nxt = zr(w_r) - zc(rd_w);
        end
      end
      ST_I_RD: begin
        if (k_r == best_r) begin
          ram_we    = 1'b1;
          ram_waddr = best_r[IW-1:0];
          ram_wdata = {px_r, CB'(zc(py_r) + zr(h_r)), CB'(w_r)};
          cnt_nxt   = cnt_r + CW'(1);
          k_nxt     = best_r + CW'(1);
          edge_nxt  = zc(px_r) + zr(w_r);
          state_nxt = ST_T_RD;
        end else begin
          ram_raddr = IW'(k_r - CW'(1));
          state_nxt = ST_I_WR;
        end
      end
      ST_I_WR: begin
        ram_we    = 1'b1;
        ram_waddr = k_r[IW-1:0];
        ram_wdata = ram_rdata;
        k_nxt     = k_r - CW'(1);
        state_nxt = ST_I_RD;
      end
      ST_T_RD: begin
        if (k_r >= cnt_r) begin
          k_nxt     = '0;
          state_nxt = ST_M_RD0;
        end else begin
          ram_raddr = k_r[IW-1:0];
          state_nxt = ST_T_PROC;
        end
      end
      ST_T_PROC: begin
        if (zc(rd_x) >= edge_r) begin
          k_nxt     = '0;
          state_nxt = ST_M_RD0;
        end else if (nw > $signed(AW'(0))) begin
          ram_we    = 1'b1;
          ram_waddr = k_r[IW-1:0];
          ram_wdata = {CB'(edge_r), rd_y, CB'(nw)};
          k_nxt     = '0;
          state_nxt = ST_M_RD0;
        end else begin
          // segment fully covered: drop it and look at the one that slides in
          j_nxt         = k_r;
          ret_merge_nxt = 1'b0;
          state_nxt     = ST_D_RD;
        end
      end
      ST_D_RD: begin
        if ({1'b0, j_r} + (CW+1)'(1) >= {1'b0, cnt_r}) begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = ret_merge_r ? ST_M_RD1 : ST_T_RD;
        end else begin
          ram_raddr = IW'(j_r + CW'(1));
          state_nxt = ST_D_WR;
        end
      end
      ST_D_WR: begin
        ram_we    = 1'b1;
        ram_waddr = j_r[IW-1:0];
        ram_wdata = ram_rdata;
        j_nxt     = j_r + CW'(1);
        state_nxt = ST_D_RD;
      end
      ST_M_RD0: begin
        if ({1'b0, k_r} + (CW+1)'(1) >= {1'b0, cnt_r}) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{found: 1'b1, pos_x: POS_BITS'(px_r), pos_y: POS_BITS'(py_r)};
          state_nxt     = ST_IDLE;
        end else begin
          ram_raddr = k_r[IW-1:0];
          state_nxt = ST_M_PR0;
        end
      end
      ST_M_PR0: begin
        cx_nxt    = rd_x;
        cy_nxt    = rd_y;
        cw_nxt    = rd_w;
        state_nxt = ST_M_RD1;
      end
      ST_M_RD1: begin
        if ({1'b0, k_r} + (CW+1)'(1) >= {1'b0, cnt_r}) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{found: 1'b1, pos_x: POS_BITS'(px_r), pos_y: POS_BITS'(py_r)};
          state_nxt     = ST_IDLE;
        end else begin
          ram_raddr = IW'(k_r + CW'(1));
          state_nxt = ST_M_PR1;
        end
      end
      ST_M_PR1: begin
        if (rd_y == cy_r) begin
          ram_we        = 1'b1;
          ram_waddr     = k_r[IW-1:0];
          ram_wdata     = {cx_r, cy_r, cw_r + rd_w};
          cw_nxt        = cw_r + rd_w;
          j_nxt         = k_r + CW'(1);
          ret_merge_nxt = 1'b1;
          state_nxt     = ST_D_RD;
        end else begin
          cx_nxt    = rd_x;
          cy_nxt    = rd_y;
          cw_nxt    = rd_w;
          k_nxt     = k_r + CW'(1);
          state_nxt = ST_M_RD1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      aw_r        <= ATLAS_SIZE_RST;
      ah_r        <= ATLAS_SIZE_RST;
      cnt_r       <= CW'(1);
      out_valid_r <= 1'b0;
      have_r      <= 1'b0;
      first_r     <= 1'b1;
      ret_merge_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      aw_r        <= aw_nxt;
      ah_r        <= ah_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      have_r      <= have_nxt;
      first_r     <= first_nxt;
      ret_merge_r <= ret_merge_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r    <= w_nxt;
    h_r    <= h_nxt;
    s_r    <= s_nxt;
    k_r    <= k_nxt;
    j_r    <= j_nxt;
    best_r <= best_nxt;
    y_r    <= y_nxt;
    left_r <= left_nxt;
    edge_r <= edge_nxt;
    btop_r <= btop_nxt;
    sw_r   <= sw_nxt;
    bw_r   <= bw_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    cw_r   <= cw_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: sv/skp_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module skp_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/skp_checker.sv
// port level checks for the skyline packer, bound to the top level
// depends on skp_pkg and skyline_rect_packer
module skp_assertions (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input skp_pkg::out_item_t out_data
);
  import skp_pkg::*;

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !out_valid) |=> (busy || out_valid))
    else $error("accepted item produced neither busy nor result");

  a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while still busy");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.found) |-> (out_data.pos_x == '0 && out_data.pos_y == '0))
    else $error("not-found result with nonzero position");

endmodule

bind skyline_rect_packer skp_assertions u_skp_assertions (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

FILE: bench/skp_checker.sv
// skyline packer checker: watches the item, result and register ports and predicts
// each result; depends on skp_pkg
`timescale 1ns / 1ps

module skp_checker #(
  parameter int MAX_SEGMENTS = skp_pkg::MAX_SEGMENTS_DEF,
  parameter int COORD_BITS   = skp_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             busy,
  input  skp_pkg::in_item_t                in_data,
  input  logic                             out_valid,
  input  skp_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [skp_pkg::CFG_IDX_BITS-1:0] cfg_addr,
  input  logic [skp_pkg::REG_BITS-1:0]     cfg_wdata,
  output int                               errors,
  output int                               pending
);
  import skp_pkg::*;

  logic [REG_BITS-1:0] width_reg, height_reg;
  int seg_x [MAX_SEGMENTS+1];
  int seg_y [MAX_SEGMENTS+1];
  int seg_w [MAX_SEGMENTS+1];
  int nseg;
  out_item_t placements[$];

  initial errors = 0;
  assign pending = placements.size();

  function automatic int clamp_size(logic [REG_BITS-1:0] v);
    if (v < 3) return 3;
    if (v > (1 << COORD_BITS)) return 1 << COORD_BITS;
    return int'(v);
  endfunction

  function automatic void reset_skyline();
    nseg = 1;
    seg_x[0] = 1;
    seg_y[0] = 1;
    seg_w[0] = clamp_size(width_reg) - 2;
  endfunction

  function automatic void remove_seg(int k);
    for (int j = k; j + 1 < nseg; j++) begin
      seg_x[j] = seg_x[j+1];
      seg_y[j] = seg_y[j+1];
      seg_w[j] = seg_w[j+1];
    end
    nseg--;
  endfunction

  // resting row for a start at segment s, -1 when it does not fit
  function automatic int resting_row(int s, int w, int h, int wa, int ha);
    int left, y, k;
    left = w;
    y = seg_y[s];
    k = s;
    if (seg_x[s] + w > wa - 1) return -1;
    while (left > 0) begin
      if (k >= nseg) return -1;
      if (seg_y[k] > y) y = seg_y[k];
      if (y + h > ha - 1) return -1;
      left -= seg_w[k];
      k++;
    end
    return y;
  endfunction

  function automatic out_item_t place_rect(in_item_t it);
    out_item_t r;
    int w, h, wa, ha, best_top, best_w, best, px, py, y, k, edge_x, cut;
    bit have;
    r = '0;
    w = int'(it.req_width);
    h = int'(it.req_height);
    wa = clamp_size(width_reg);
    ha = clamp_size(height_reg);
    best_top = 32'h7fffffff;
    best_w = 32'h7fffffff;
    best = 0; px = 0; py = 0;
    have = 0;
    if (it.kind == KIND_CLEAR) begin
      reset_skyline();
      return r;
    end
    if (w == 0 || h == 0 || nseg >= MAX_SEGMENTS) return r;
    for (k = 0; k < nseg; k++) begin
      y = resting_row(k, w, h, wa, ha);
      if (y >= 0 && (y + h < best_top || (y + h == best_top && seg_w[k] < best_w))) begin
        best_top = y + h;
        best_w = seg_w[k];
        best = k;
        px = seg_x[k];
        py = y;
        have = 1;
      end
    end
    if (!have) return r;
    for (k = nseg; k > best; k--) begin
      seg_x[k] = seg_x[k-1];
      seg_y[k] = seg_y[k-1];
      seg_w[k] = seg_w[k-1];
    end
    seg_x[best] = px;
    seg_y[best] = py + h;
    seg_w[best] = w;
    nseg++;
    // trim or drop what the new segment covers
    k = best + 1;
    while (k < nseg) begin
      edge_x = seg_x[k-1] + seg_w[k-1];
      if (seg_x[k] >= edge_x) break;
      cut = edge_x - seg_x[k];
      seg_x[k] += cut;
      seg_w[k] -= cut;
      if (seg_w[k] <= 0) remove_seg(k);
      else break;
    end
    k = 0;
    while (k + 1 < nseg) begin
      if (seg_y[k] == seg_y[k+1]) begin
        seg_w[k] += seg_w[k+1];
        remove_seg(k + 1);
      end else begin
        k++;
      end
    end
    r.found = 1'b1;
    r.pos_x = px[POS_BITS-1:0];
    r.pos_y = py[POS_BITS-1:0];
    return r;
  endfunction

  task automatic report(string what, int want, int got);
    $display("%0t mismatch %s: expected %0d got %0d", $time, what, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      width_reg = ATLAS_SIZE_RST;
      height_reg = ATLAS_SIZE_RST;
      reset_skyline();
      placements.delete();
    end else begin
      if (out_valid) begin
        if (placements.size() == 0) begin
          $display("%0t unexpected result transfer", $time);
          errors++;
        end else begin
          want = placements.pop_front();
          if (out_data.found !== want.found) report("found", want.found, out_data.found);
          if (out_data.pos_x !== want.pos_x) report("pos_x", want.pos_x, out_data.pos_x);
          if (out_data.pos_y !== want.pos_y) report("pos_y", want.pos_y, out_data.pos_y);
        end
      end
      if (start && !busy) placements.push_back(place_rect(in_data));
      if (cfg_we) begin
        if (cfg_addr == REG_ATLAS_WIDTH) width_reg = cfg_wdata;
        else height_reg = cfg_wdata;
      end
    end
  end

endmodule

FILE: bench/tb_skyline_rect_packer.sv
// skyline packer testbench top: clock, reset, item and register stimulus, verdict
// depends on skp_pkg, skyline_rect_packer and skp_checker
`timescale 1ns / 1ps

module tb_skyline_rect_packer;
  import skp_pkg::*;

  logic clk, rst_n, start, busy, out_valid, cfg_we;
  in_item_t in_data;
  out_item_t out_data;
  logic [CFG_IDX_BITS-1:0] cfg_addr;
  logic [REG_BITS-1:0] cfg_wdata;
  int errors, pending;
  bit no_idle;

  skyline_rect_packer dut (.*);

  skp_checker chk (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  task automatic send(logic kind, int w, int h);
    while (!no_idle && $urandom_range(99) < 29) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= '{kind, w[REG_BITS-1:0], h[REG_BITS-1:0]};
    do @(posedge clk); while (busy);
  endtask

  task automatic set_reg(logic [CFG_IDX_BITS-1:0] idx, int v);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v[REG_BITS-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n, int wmax, int hmax);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 7) send(KIND_CLEAR, $urandom, $urandom);
      else if (r < 12) send(KIND_REQUEST, $urandom_range(8191), $urandom_range(8191));
      else if (r < 15) send(KIND_REQUEST, $urandom_range(1) * $urandom_range(9),
                            $urandom_range(9) * $urandom_range(1));
      else send(KIND_REQUEST, $urandom_range(1, wmax), $urandom_range(1, hmax));
    end
  endtask

  initial begin
    #100ms;
    $display("skyline_rect_packer verification failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_data = '0;
    no_idle = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, zero sizes, clear
    send(KIND_REQUEST, 1, 1);
    send(KIND_REQUEST, 510, 1);
    send(KIND_REQUEST, 511, 1);
    send(KIND_REQUEST, 0, 5);
    send(KIND_REQUEST, 5, 0);
    send(KIND_REQUEST, 8191, 8191);
    send(KIND_REQUEST, 1, 509);
    send(KIND_CLEAR, 8191, 8191);
    // distinct heights side by side fill the segment store
    for (int i = 1; i <= 66; i++) send(KIND_REQUEST, 1, i);
    send(KIND_CLEAR, 0, 0);

    set_reg(REG_ATLAS_WIDTH, 0);
    set_reg(REG_ATLAS_HEIGHT, 2);
    send(KIND_REQUEST, 1, 1);
    send(KIND_CLEAR, 0, 0);
    send(KIND_REQUEST, 1, 1);
    send(KIND_REQUEST, 1, 1);
    set_reg(REG_ATLAS_WIDTH, 8191);
    set_reg(REG_ATLAS_HEIGHT, 8191);
    // width grew without a clear: span runs past the skyline
    send(KIND_REQUEST, 2, 1);
    send(KIND_CLEAR, 0, 0);
    send(KIND_REQUEST, 4094, 4094);
    send(KIND_REQUEST, 4094, 1);
    send(KIND_CLEAR, 0, 0);

    // random phases over several atlas sizes
    set_reg(REG_ATLAS_WIDTH, 64);
    set_reg(REG_ATLAS_HEIGHT, 48);
    send(KIND_CLEAR, 0, 0);
    random_phase(12, 12, 10);
    no_idle = 1;
    set_reg(REG_ATLAS_WIDTH, 4096);
    set_reg(REG_ATLAS_HEIGHT, 4096);
    random_phase(16, 300, 300);
    no_idle = 0;
    set_reg(REG_ATLAS_WIDTH, 3);
    set_reg(REG_ATLAS_HEIGHT, 3);
    send(KIND_CLEAR, 0, 0);
    random_phase(5, 2, 2);
    set_reg(REG_ATLAS_WIDTH, $urandom_range(20, 200));
    set_reg(REG_ATLAS_HEIGHT, $urandom_range(20, 200));
    send(KIND_CLEAR, 0, 0);
    random_phase(8, 16, 16);
    set_reg(REG_ATLAS_WIDTH, 512);
    set_reg(REG_ATLAS_HEIGHT, 512);
    random_phase(12, 40, 40);

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("skyline_rect_packer verification clean");
    end else begin
      $display("skyline_rect_packer verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/skp_pkg.sv
sv/skp_ram.sv
sv/skyline_rect_packer.sv
sv/skp_checker.sv
bench/skp_checker.sv
bench/tb_skyline_rect_packer.sv
